FILE: design/tlpq_pkg.sv
// Shared types and codes for the two-level priority event queue.
package tlpq_pkg;

  // Request operation codes
  typedef enum logic [2:0] {
    MODE_SEND  = 3'd0,
    MODE_POP   = 3'd1,
    MODE_PEEK  = 3'd2,
    MODE_CLEAR = 3'd3,
    MODE_STATS = 3'd4
  } mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_BAD_TYPE = 2'd3
  } status_e;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  // Stored event tag, 57 bits
  typedef struct packed {
    logic [15:0] qnum;
    logic [15:0] ev_id;
    logic        flag;
    logic [7:0]  ev_type;
    logic [15:0] node_id;
  } tag_t;

  // One ring slot: tag and payload
  typedef struct packed {
    tag_t        tag;
    logic [63:0] payload;
  } entry_t;

  // Per-cycle commands to one ring
  typedef struct packed {
    logic push;   // write slot at write pointer, advance it
    logic adv;    // advance read pointer
    logic rd_en;  // read slot at read pointer
    logic clr;    // empty the ring
  } ring_ctrl_t;

endpackage

FILE: design/tlpq_ring.sv
// One event ring: slot memory with registered read port and its pointers.
module tlpq_ring #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tlpq_pkg::ring_ctrl_t       ctrl_i,
  input  tlpq_pkg::entry_t           wr_data_i,
  output tlpq_pkg::entry_t           rd_data_o,
  output logic [$clog2(DEPTH)-1:0]   count_o,
  output logic                       empty_o,
  output logic                       full_o
);
  import tlpq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  entry_t          mem [DEPTH];
  entry_t          rd_q;
  logic [AW-1:0]   wptr_q, wptr_d;
  logic [AW-1:0]   rptr_q, rptr_d;

  // Occupancy and flags; one slot is always left unused
  assign count_o = wptr_q - rptr_q;
  assign empty_o = (wptr_q == rptr_q);
  assign full_o  = ((wptr_q + AW'(1)) == rptr_q);

  // Advance pointers
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (ctrl_i.push) begin
      wptr_d = wptr_q + AW'(1);
    end
    if (ctrl_i.adv) begin
      rptr_d = rptr_q + AW'(1);
    end
    if (ctrl_i.clr) begin
      rptr_d = wptr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  // Slot memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[wptr_q] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem[rptr_q];
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: design/tlpq_stats.sv
// High-water marks for the high ring and for both rings together.
module tlpq_stats #(
  parameter int unsigned HW = 4,
  parameter int unsigned TW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          upd_i,
  input  logic          clr_i,
  input  logic [HW-1:0] high_i,
  input  logic [TW-1:0] total_i,
  output logic [HW-1:0] peak_high_o,
  output logic [TW-1:0] peak_total_o
);

  logic [HW-1:0] peak_high_q, peak_high_d;
  logic [TW-1:0] peak_total_q, peak_total_d;

  // Raise marks after a push, drop them on a statistics reset
  always_comb begin
    peak_high_d  = peak_high_q;
    peak_total_d = peak_total_q;
    if (clr_i) begin
      peak_high_d  = '0;
      peak_total_d = '0;
    end else if (upd_i) begin
      if (high_i > peak_high_q) begin
        peak_high_d = high_i;
      end
      if (total_i > peak_total_q) begin
        peak_total_d = total_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_high_q  <= '0;
      peak_total_q <= '0;
    end else begin
      peak_high_q  <= peak_high_d;
      peak_total_q <= peak_total_d;
    end
  end

  // Marks as they stand after the current step
  assign peak_high_o  = peak_high_d;
  assign peak_total_o = peak_total_d;

endmodule

FILE: design/two_level_priority_event_queue.sv
// Two-level strict-priority event queue: top level with controller and result register.
//
// Requests arrive on in_valid_i/in_ready_o with mode_i and the event fields;
// each request yields exactly one result on out_valid_o/out_ready_i.
// Send, clear, statistics reset, unknown modes and pop/peek on two empty
// rings complete at the accepting edge: the result is valid the next cycle,
// and a new request may be accepted every cycle while results are taken.
// Pop and peek of a stored event read the slot memory, whose read port is
// registered, so such a request holds the input in the read state and its
// result is loaded once the result register is free; no request is taken before.
// The result register decouples the sides: a request is accepted while a
// result is waiting, provided that result is taken in the same cycle;
// a stalled receiver holds the result and blocks further requests.
// cfg_we_i writes the queue number stamped into later pushed events.
// Reset empties both rings and clears the high-water marks and queue
// number; no clearing pass is needed, the block is ready right after reset.
module two_level_priority_event_queue #(
  parameter int unsigned HI_DEPTH    = 16,
  parameter int unsigned LOW_DEPTH   = 16,
  parameter int unsigned MAX_EV_TYPE = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic        priority_req_i,
  input  logic [15:0] node_id_i,
  input  logic [7:0]  ev_type_i,
  input  logic        malloc_mark_i,
  input  logic [15:0] ev_id_i,
  input  logic [63:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] out_node_id_o,
  output logic [7:0]  out_ev_type_o,
  output logic        out_flags_o,
  output logic [15:0] out_ev_id_o,
  output logic [15:0] out_qnum_o,
  output logic [63:0] out_payload_o,
  output logic [3:0]  high_count_o,
  output logic [3:0]  low_count_o,
  output logic [3:0]  hwm_high_o,
  output logic [4:0]  hwm_total_o
);
  import tlpq_pkg::*;

  localparam int unsigned HAW = $clog2(HI_DEPTH);
  localparam int unsigned LAW = $clog2(LOW_DEPTH);
  localparam int unsigned TW  = ((HAW > LAW) ? HAW : LAW) + 1;

  state_e        state_q, state_d;
  logic          sel_high_q, sel_high_d;
  logic [15:0]   qnum_q;

  ring_ctrl_t    hi_ctrl, lo_ctrl;
  entry_t        wr_entry, hi_rd, lo_rd;
  logic [HAW-1:0] hi_count, h_res;
  logic [LAW-1:0] lo_count, l_res;
  logic          hi_empty, hi_full, lo_empty, lo_full;

  logic          stat_upd, stat_clr;
  logic [HAW-1:0] peak_high;
  logic [TW-1:0]  peak_total;

  logic          acc, out_free, load_res;
  status_e       res_status;
  entry_t        res_entry;
  logic [31:0]   h_res_w, l_res_w, pk_h_w, pk_t_w;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    status_q;
  entry_t        entry_q;
  logic [3:0]    hcnt_q, lcnt_q, mh_q;
  logic [4:0]    mt_q;

  // Queue number register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qnum_q <= '0;
    end else if (cfg_we_i) begin
      qnum_q <= cfg_wdata_i;
    end
  end

  // Event to push, stamped with the current queue number
  always_comb begin
    wr_entry.tag.node_id = node_id_i;
    wr_entry.tag.ev_type = ev_type_i;
    wr_entry.tag.flag    = malloc_mark_i;
    wr_entry.tag.ev_id   = ev_id_i;
    wr_entry.tag.qnum    = qnum_q;
    wr_entry.payload     = payload_i;
  end

  tlpq_ring #(.DEPTH(HI_DEPTH)) u_high_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (hi_ctrl),
    .wr_data_i (wr_entry),
    .rd_data_o (hi_rd),
    .count_o   (hi_count),
    .empty_o   (hi_empty),
    .full_o    (hi_full)
  );

  tlpq_ring #(.DEPTH(LOW_DEPTH)) u_low_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (lo_ctrl),
    .wr_data_i (wr_entry),
    .rd_data_o (lo_rd),
    .count_o   (lo_count),
    .empty_o   (lo_empty),
    .full_o    (lo_full)
  );

  // Handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign acc        = in_valid_i && in_ready_o;

  // Decode the request, drive the rings, step the controller
  always_comb begin
    state_d    = state_q;
    sel_high_d = sel_high_q;
    hi_ctrl    = '0;
    lo_ctrl    = '0;
    stat_upd   = 1'b0;
    stat_clr   = 1'b0;
    res_status = STAT_OK;
    res_entry  = '0;
    load_res   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          load_res = 1'b1;
          unique case (mode_i) inside
            MODE_SEND: begin
              if (ev_type_i > 8'(MAX_EV_TYPE)) begin
                res_status = STAT_BAD_TYPE;
              end else if (priority_req_i) begin
                if (hi_full) begin
                  res_status = STAT_FULL;
                end else begin
                  hi_ctrl.push = 1'b1;
                  stat_upd     = 1'b1;
                end
              end else begin
                if (lo_full) begin
                  res_status = STAT_FULL;
                end else begin
                  lo_ctrl.push = 1'b1;
                  stat_upd     = 1'b1;
                end
              end
            end
            MODE_POP, MODE_PEEK: begin
              if (!hi_empty) begin
                hi_ctrl.rd_en = 1'b1;
                hi_ctrl.adv   = (mode_i == MODE_POP);
                sel_high_d    = 1'b1;
                load_res      = 1'b0;
                state_d       = ST_READ;
              end else if (!lo_empty) begin
                lo_ctrl.rd_en = 1'b1;
                lo_ctrl.adv   = (mode_i == MODE_POP);
                sel_high_d    = 1'b0;
                load_res      = 1'b0;
                state_d       = ST_READ;
              end else begin
                res_status = STAT_EMPTY;
              end
            end
            MODE_CLEAR: begin
              hi_ctrl.clr = 1'b1;
              lo_ctrl.clr = 1'b1;
            end
            MODE_STATS: begin
              stat_clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        // Slot data is registered; hand it over once the result register frees
        res_entry = sel_high_q ? hi_rd : lo_rd;
        if (out_free) begin
          load_res = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      sel_high_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      sel_high_q <= sel_high_d;
    end
  end

  // Occupancies after this step
  always_comb begin
    h_res = hi_ctrl.clr ? '0 : hi_count + HAW'(hi_ctrl.push);
    l_res = lo_ctrl.clr ? '0 : lo_count + LAW'(lo_ctrl.push);
  end

  tlpq_stats #(.HW(HAW), .TW(TW)) u_stats (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .upd_i        (stat_upd),
    .clr_i        (stat_clr),
    .high_i       (h_res),
    .total_i      (TW'(h_res) + TW'(l_res)),
    .peak_high_o  (peak_high),
    .peak_total_o (peak_total)
  );

  // Fit counts to the result field widths
  assign h_res_w = 32'(h_res);
  assign l_res_w = 32'(l_res);
  assign pk_h_w  = 32'(peak_high);
  assign pk_t_w  = 32'(peak_total);

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_res) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (load_res) begin
      status_q <= res_status;
      entry_q  <= res_entry;
      hcnt_q   <= h_res_w[3:0];
      lcnt_q   <= l_res_w[3:0];
      mh_q     <= pk_h_w[3:0];
      mt_q     <= pk_t_w[4:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_node_id_o = entry_q.tag.node_id;
  assign out_ev_type_o = entry_q.tag.ev_type;
  assign out_flags_o   = entry_q.tag.flag;
  assign out_ev_id_o   = entry_q.tag.ev_id;
  assign out_qnum_o    = entry_q.tag.qnum;
  assign out_payload_o = entry_q.payload;
  assign high_count_o  = hcnt_q;
  assign low_count_o   = lcnt_q;
  assign hwm_high_o    = mh_q;
  assign hwm_total_o   = mt_q;

`ifndef NO_ASSERTIONS
  // A full ring never takes a push
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hi_ctrl.push |-> !hi_full) and (lo_ctrl.push |-> !lo_full))
    else $error("push into a full ring");

  // At most one ring operation per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({hi_ctrl.push, lo_ctrl.push, hi_ctrl.rd_en, lo_ctrl.rd_en}))
    else $error("more than one ring operation in a cycle");

  // A slot read is followed by the read state, which accepts no request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hi_ctrl.rd_en || lo_ctrl.rd_en) |=> (state_q == ST_READ) && !in_ready_o)
    else $error("slot read not followed by read state");
`endif

endmodule

FILE: verif/tlpq_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the two-level priority event queue: mirrors both rings and compares results.
module tlpq_result_checker #(
  parameter int unsigned HI_DEPTH    = 16,
  parameter int unsigned LOW_DEPTH   = 16,
  parameter int unsigned MAX_EV_TYPE = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  mode_i,
  input  logic        priority_req_i,
  input  logic [15:0] node_id_i,
  input  logic [7:0]  ev_type_i,
  input  logic        malloc_mark_i,
  input  logic [15:0] ev_id_i,
  input  logic [63:0] payload_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [15:0] out_node_id_i,
  input  logic [7:0]  out_ev_type_i,
  input  logic        out_flags_i,
  input  logic [15:0] out_ev_id_i,
  input  logic [15:0] out_qnum_i,
  input  logic [63:0] out_payload_i,
  input  logic [3:0]  high_count_i,
  input  logic [3:0]  low_count_i,
  input  logic [3:0]  hwm_high_i,
  input  logic [4:0]  hwm_total_i,
  output int unsigned mismatch_count_o,
  output int unsigned awaited_o
);
  import tlpq_pkg::*;

  localparam int HW = $clog2(HI_DEPTH);
  localparam int LW = $clog2(LOW_DEPTH);

  // One predicted result
  typedef struct packed {
    status_e     status;
    tag_t        tag;
    logic [63:0] payload;
    logic [3:0]  high_count;
    logic [3:0]  low_count;
    logic [3:0]  hwm_high;
    logic [4:0]  hwm_total;
  } outcome_t;

  // Mirror of the rings, pointers and high-water marks
  tag_t          high_tags [HI_DEPTH];
  logic [63:0]   high_words [HI_DEPTH];
  tag_t          low_tags [LOW_DEPTH];
  logic [63:0]   low_words [LOW_DEPTH];
  logic [HW-1:0] high_wr, high_rd;
  logic [LW-1:0] low_wr, low_rd;
  int unsigned   peak_high, peak_all;
  logic [15:0]   stamp;

  outcome_t      awaited_results [$];
  outcome_t      want;
  int unsigned   mismatches;

  function automatic logic [HW-1:0] high_fill();
    return high_wr - high_rd;
  endfunction

  function automatic logic [LW-1:0] low_fill();
    return low_wr - low_rd;
  endfunction

  // Apply one request to the mirror and return the result it should produce
  function automatic outcome_t apply_request(logic [2:0] mode, logic prio, logic [15:0] node,
                                             logic [7:0] etype, logic mark, logic [15:0] id,
                                             logic [63:0] word);
    outcome_t    res;
    tag_t        t;
    int unsigned h, tot;
    res = '0;
    res.status = STAT_OK;
    case (mode) inside
      MODE_SEND: begin
        // type check comes before the full check
        if (etype > MAX_EV_TYPE) begin
          res.status = STAT_BAD_TYPE;
        end else begin
          t.qnum    = stamp;
          t.ev_id   = id;
          t.flag    = mark;
          t.ev_type = etype;
          t.node_id = node;
          if (prio) begin
            if ((high_wr + 1'b1) == high_rd) begin
              res.status = STAT_FULL;
            end else begin
              high_tags[high_wr]  = t;
              high_words[high_wr] = word;
              high_wr             = high_wr + 1'b1;
            end
          end else begin
            if ((low_wr + 1'b1) == low_rd) begin
              res.status = STAT_FULL;
            end else begin
              low_tags[low_wr]  = t;
              low_words[low_wr] = word;
              low_wr            = low_wr + 1'b1;
            end
          end
          if (res.status == STAT_OK) begin
            h   = high_fill();
            tot = h + low_fill();
            if (h > peak_high) peak_high = h;
            if (tot > peak_all) peak_all = tot;
          end
        end
      end
      MODE_POP, MODE_PEEK: begin
        // serve the high ring first
        if (high_wr != high_rd) begin
          res.tag     = high_tags[high_rd];
          res.payload = high_words[high_rd];
          if (mode == MODE_POP) high_rd = high_rd + 1'b1;
        end else if (low_wr != low_rd) begin
          res.tag     = low_tags[low_rd];
          res.payload = low_words[low_rd];
          if (mode == MODE_POP) low_rd = low_rd + 1'b1;
        end else begin
          res.status = STAT_EMPTY;
        end
      end
      MODE_CLEAR: begin
        high_rd = high_wr;
        low_rd  = low_wr;
      end
      MODE_STATS: begin
        peak_high = 0;
        peak_all  = 0;
      end
      default: begin
      end
    endcase
    res.high_count = high_fill();
    res.low_count  = low_fill();
    res.hwm_high   = peak_high[3:0];
    res.hwm_total  = peak_all[4:0];
    return res;
  endfunction

  task automatic check_field(string name, logic [63:0] expected, logic [63:0] actual);
    if (expected !== actual) begin
      $error("%s: expected %0h, actual %0h", name, expected, actual);
      mismatches++;
    end
  endtask

  // Compare the result taken at this edge, then record the request accepted at it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_wr    = '0;
      high_rd    = '0;
      low_wr     = '0;
      low_rd     = '0;
      peak_high  = 0;
      peak_all   = 0;
      stamp      = '0;
      mismatches = 0;
      awaited_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request awaiting it: status %0d", status_i);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, status_i);
          check_field("out_node_id", want.tag.node_id, out_node_id_i);
          check_field("out_ev_type", want.tag.ev_type, out_ev_type_i);
          check_field("out_flags", want.tag.flag, out_flags_i);
          check_field("out_ev_id", want.tag.ev_id, out_ev_id_i);
          check_field("out_qnum", want.tag.qnum, out_qnum_i);
          check_field("out_payload", want.payload, out_payload_i);
          check_field("high_count", want.high_count, high_count_i);
          check_field("low_count", want.low_count, low_count_i);
          check_field("hwm_high", want.hwm_high, hwm_high_i);
          check_field("hwm_total", want.hwm_total, hwm_total_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(apply_request(mode_i, priority_req_i, node_id_i,
                                                ev_type_i, malloc_mark_i, ev_id_i,
                                                payload_i));
      end
      if (cfg_we_i) stamp = cfg_wdata_i;
    end
    awaited_o        = awaited_results.size();
    mismatch_count_o = mismatches;
  end

endmodule

FILE: verif/two_level_priority_event_queue_tb.sv
`timescale 1ns / 1ps
// Testbench top for the two-level priority event queue: stimulus, idling and verdict.
module two_level_priority_event_queue_tb;
  import tlpq_pkg::*;

  localparam int unsigned HI_DEPTH       = 16;
  localparam int unsigned LOW_DEPTH      = 16;
  localparam int unsigned MAX_EV_TYPE    = 15;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned PHASE_REQUESTS = 245;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  mode_i;
  logic        priority_req_i;
  logic [15:0] node_id_i;
  logic [7:0]  ev_type_i;
  logic        malloc_mark_i;
  logic [15:0] ev_id_i;
  logic [63:0] payload_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [15:0] out_node_id_o;
  logic [7:0]  out_ev_type_o;
  logic        out_flags_o;
  logic [15:0] out_ev_id_o;
  logic [15:0] out_qnum_o;
  logic [63:0] out_payload_o;
  logic [3:0]  high_count_o;
  logic [3:0]  low_count_o;
  logic [3:0]  hwm_high_o;
  logic [4:0]  hwm_total_o;

  int unsigned mismatches;
  int unsigned awaited;
  int unsigned sender_gap_pct;
  int unsigned receiver_stall_pct;
  int unsigned quiet_cycles;

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  two_level_priority_event_queue #(
    .HI_DEPTH    (HI_DEPTH),
    .LOW_DEPTH   (LOW_DEPTH),
    .MAX_EV_TYPE (MAX_EV_TYPE)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .priority_req_i (priority_req_i),
    .node_id_i      (node_id_i),
    .ev_type_i      (ev_type_i),
    .malloc_mark_i  (malloc_mark_i),
    .ev_id_i        (ev_id_i),
    .payload_i      (payload_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_node_id_o  (out_node_id_o),
    .out_ev_type_o  (out_ev_type_o),
    .out_flags_o    (out_flags_o),
    .out_ev_id_o    (out_ev_id_o),
    .out_qnum_o     (out_qnum_o),
    .out_payload_o  (out_payload_o),
    .high_count_o   (high_count_o),
    .low_count_o    (low_count_o),
    .hwm_high_o     (hwm_high_o),
    .hwm_total_o    (hwm_total_o)
  );

  tlpq_result_checker #(
    .HI_DEPTH    (HI_DEPTH),
    .LOW_DEPTH   (LOW_DEPTH),
    .MAX_EV_TYPE (MAX_EV_TYPE)
  ) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .mode_i           (mode_i),
    .priority_req_i   (priority_req_i),
    .node_id_i        (node_id_i),
    .ev_type_i        (ev_type_i),
    .malloc_mark_i    (malloc_mark_i),
    .ev_id_i          (ev_id_i),
    .payload_i        (payload_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_i         (status_o),
    .out_node_id_i    (out_node_id_o),
    .out_ev_type_i    (out_ev_type_o),
    .out_flags_i      (out_flags_o),
    .out_ev_id_i      (out_ev_id_o),
    .out_qnum_i       (out_qnum_o),
    .out_payload_i    (out_payload_o),
    .high_count_i     (high_count_o),
    .low_count_i      (low_count_o),
    .hwm_high_i       (hwm_high_o),
    .hwm_total_i      (hwm_total_o),
    .mismatch_count_o (mismatches),
    .awaited_o        (awaited)
  );

  // Stall the result side at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Abort when no request or result moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic issue(logic [2:0] mode, logic prio, logic [15:0] node, logic [7:0] etype,
                       logic mark, logic [15:0] id, logic [63:0] word);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    mode_i         <= mode;
    priority_req_i <= prio;
    node_id_i      <= node;
    ev_type_i      <= etype;
    malloc_mark_i  <= mark;
    ev_id_i        <= id;
    payload_i      <= word;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Drain all outstanding results so the block is idle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic program_qnum(logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly random 16-bit values, with the extremes now and then
  function automatic logic [15:0] pick16();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [63:0] pick64();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Random requests in bursts that lean towards filling or draining the rings, or keep them balanced
  task automatic run_random(int unsigned count);
    int unsigned r, send_lim, pop_lim, peek_lim, clear_lim, stats_lim, high_pct;
    logic [2:0]  mode;
    logic [7:0]  etype;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: begin
            send_lim = 70; pop_lim = 82; peek_lim = 90; clear_lim = 92; stats_lim = 96;
            high_pct = $urandom_range(1) ? 85 : 15;
          end
          1: begin
            send_lim = 30; pop_lim = 80; peek_lim = 92; clear_lim = 94; stats_lim = 97;
            high_pct = 50;
          end
          default: begin
            send_lim = 50; pop_lim = 75; peek_lim = 90; clear_lim = 93; stats_lim = 97;
            high_pct = 50;
          end
        endcase
      end
      r = $urandom_range(99);
      if (r < send_lim)       mode = MODE_SEND;
      else if (r < pop_lim)   mode = MODE_POP;
      else if (r < peek_lim)  mode = MODE_PEEK;
      else if (r < clear_lim) mode = MODE_CLEAR;
      else if (r < stats_lim) mode = MODE_STATS;
      else                    mode = 3'($urandom_range(5, 7));
      // mostly legal types, the rest just past the limit, at 255 or at random beyond it
      r = $urandom_range(99);
      if (r < 80)      etype = 8'($urandom_range(MAX_EV_TYPE));
      else if (r < 85) etype = 8'(MAX_EV_TYPE + 1);
      else if (r < 88) etype = 8'hFF;
      else             etype = 8'($urandom_range(255, MAX_EV_TYPE + 1));
      issue(mode, $urandom_range(99) < high_pct, pick16(), etype, 1'($urandom),
            pick16(), pick64());
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    in_valid_i         = 1'b0;
    mode_i             = MODE_SEND;
    priority_req_i     = 1'b0;
    node_id_i          = '0;
    ev_type_i          = '0;
    malloc_mark_i      = 1'b0;
    ev_id_i            = '0;
    payload_i          = '0;
    sender_gap_pct     = 17;
    receiver_stall_pct = 57;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    program_qnum(16'hFFFF);

    // Directed: empty rings, field extremes, type refusals, priority order, odd modes
    issue(MODE_POP, 1'b0, '0, '0, 1'b0, '0, '0);
    issue(MODE_PEEK, 1'b0, '0, '0, 1'b0, '0, '0);
    issue(MODE_SEND, 1'b0, 16'h0000, 8'h00, 1'b0, 16'h0000, '0);
    issue(MODE_SEND, 1'b1, 16'hFFFF, 8'(MAX_EV_TYPE), 1'b1, 16'hFFFF, '1);
    issue(MODE_SEND, 1'b1, 16'h1234, 8'(MAX_EV_TYPE + 1), 1'b1, 16'h4321, pick64());
    issue(MODE_SEND, 1'b0, 16'hABCD, 8'hFF, 1'b0, 16'hDCBA, pick64());
    issue(MODE_PEEK, 1'b0, '0, '0, 1'b0, '0, '0);
    issue(MODE_POP, 1'b0, '0, '0, 1'b0, '0, '0);
    issue(MODE_PEEK, 1'b0, '0, '0, 1'b0, '0, '0);
    issue(MODE_POP, 1'b0, '0, '0, 1'b0, '0, '0);
    issue(MODE_POP, 1'b0, '0, '0, 1'b0, '0, '0);
    issue(MODE_SEND, 1'b0, pick16(), 8'd7, 1'b1, pick16(), pick64());
    issue(3'd5, 1'b1, '1, '1, 1'b1, '1, '1);
    issue(3'd6, 1'b0, '0, '0, 1'b0, '0, '0);
    issue(3'd7, 1'b1, pick16(), 8'd3, 1'b0, pick16(), pick64());
    issue(MODE_STATS, 1'b0, '0, '0, 1'b0, '0, '0);
    issue(MODE_SEND, 1'b1, pick16(), 8'd1, 1'b0, pick16(), pick64());
    issue(MODE_CLEAR, 1'b0, '0, '0, 1'b0, '0, '0);
    issue(MODE_PEEK, 1'b0, '0, '0, 1'b0, '0, '0);

    run_random(PHASE_REQUESTS);

    // Swap the idling sides and restamp with the lowest queue number
    settle();
    sender_gap_pct     = 57;
    receiver_stall_pct = 17;
    program_qnum(16'h0000);
    run_random(PHASE_REQUESTS);

    // Full rate on both sides
    settle();
    sender_gap_pct     = 0;
    receiver_stall_pct = 0;
    program_qnum(16'($urandom));
    run_random(PHASE_REQUESTS);

    settle();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/tlpq_pkg.sv
design/tlpq_ring.sv
design/tlpq_stats.sv
design/two_level_priority_event_queue.sv
verif/tlpq_result_checker.sv
verif/two_level_priority_event_queue_tb.sv
